// ===== design/four_way_cache_tag_store_macros.svh =====
// assertion macros for the four-way cache tag store
// clocked on clk_i, disabled while rst_ni is low; the including module supplies both
`ifndef FOUR_WAY_CACHE_TAG_STORE_MACROS_SVH
`define FOUR_WAY_CACHE_TAG_STORE_MACROS_SVH

// property checked at every edge
`define FWCTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define FWCTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/fwcts_pkg.sv =====
// shared types, constants and helper functions of the cache tag store
// no dependencies
`timescale 1ns / 1ps

package fwcts_pkg;

  localparam int ADDR_W     = 32;
  localparam int WAYS       = 4;
  localparam int WAY_W      = 2;
  localparam int AGE_W      = 2;
  localparam int SEED_W     = 16;
  localparam int CNT_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [AGE_W-1:0]  AGE_MAX    = 2'd3;
  localparam logic [SEED_W-1:0] SEED_RESET = 16'd44257;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POLICY = 2'd0,
    REG_SEED   = 2'd1
  } cfg_reg_e;

  typedef enum logic {
    POL_FIFO   = 1'b0,
    POL_RANDOM = 1'b1
  } policy_e;

  typedef enum logic [2:0] {
    ST_CLEAR  = 3'b001,
    ST_IDLE   = 3'b010,
    ST_LOOKUP = 3'b100
  } state_e;

  // outcome of one lookup, from the way logic to the controller
  typedef struct packed {
    logic             hit;
    logic             filled;
    logic [WAY_W-1:0] way;
    logic             rand_adv;
  } lookup_t;

  // fibonacci lfsr, taps x^16 + x^14 + x^13 + x^11 + 1
  function automatic logic [SEED_W-1:0] lfsr_next(input logic [SEED_W-1:0] s);
    logic b;
    b = s[0] ^ s[2] ^ s[3] ^ s[5];
    return {b, s[SEED_W-1:1]};
  endfunction

  // a zero seed would lock the generator
  function automatic logic [SEED_W-1:0] seed_load(input logic [SEED_W-1:0] s);
    return (s == '0) ? {{(SEED_W-1){1'b0}}, 1'b1} : s;
  endfunction

endpackage

// ===== design/fwcts_if.sv =====
// valid/ready channels of the cache tag store: address in, result out, config write
// depends on fwcts_pkg
`timescale 1ns / 1ps

interface fwcts_addr_if;
  import fwcts_pkg::*;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] address;
  modport source (output valid, output address, input ready);
  modport sink (input valid, input address, output ready);
endinterface

interface fwcts_res_if;
  import fwcts_pkg::*;
  logic             valid;
  logic             ready;
  logic             hit;
  logic             filled_empty;
  logic [WAY_W-1:0] way_used;
  logic [CNT_W-1:0] reference_total;
  logic [CNT_W-1:0] miss_total;
  modport source (output valid, output hit, output filled_empty, output way_used,
                  output reference_total, output miss_total, input ready);
  modport sink (input valid, input hit, input filled_empty, input way_used,
                input reference_total, input miss_total, output ready);
endinterface

interface fwcts_cfg_if;
  import fwcts_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/fwcts_tag_ram.sv =====
// one-row-per-set memory holding valid bits, ages and tags of all four ways
// single write port, single registered read port; no package use
`timescale 1ns / 1ps

module fwcts_tag_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 80,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/fwcts_way_logic.sv =====
// tag compare, victim choice and row update for one set
// depends on fwcts_pkg
`timescale 1ns / 1ps

module fwcts_way_logic #(
  parameter int unsigned TAG_W = 16
) (
  input  logic [fwcts_pkg::WAYS-1:0]                        valid_i,
  input  logic [fwcts_pkg::WAYS-1:0][fwcts_pkg::AGE_W-1:0]  age_i,
  input  logic [fwcts_pkg::WAYS-1:0][TAG_W-1:0]             tag_i,
  input  logic [TAG_W-1:0]                                  lookup_tag_i,
  input  fwcts_pkg::policy_e                                policy_i,
  input  logic [fwcts_pkg::WAY_W-1:0]                       rand_way_i,
  output fwcts_pkg::lookup_t                                res_o,
  output logic [fwcts_pkg::WAYS-1:0]                        valid_o,
  output logic [fwcts_pkg::WAYS-1:0][fwcts_pkg::AGE_W-1:0]  age_o,
  output logic [fwcts_pkg::WAYS-1:0][TAG_W-1:0]             tag_o
);

  import fwcts_pkg::*;

  logic             hit;
  logic [WAY_W-1:0] hit_way;
  logic             full;
  logic [WAY_W-1:0] free_way;
  logic [WAY_W-1:0] old_way;
  logic [AGE_W-1:0] old_age;
  logic [WAY_W-1:0] way;

  // lowest matching way and lowest invalid way
  always_comb begin
    hit      = 1'b0;
    hit_way  = '0;
    full     = 1'b1;
    free_way = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (valid_i[i] && (tag_i[i] == lookup_tag_i)) begin
        hit     = 1'b1;
        hit_way = WAY_W'(i);
      end
      if (!valid_i[i]) begin
        full     = 1'b0;
        free_way = WAY_W'(i);
      end
    end
  end

  // lowest way with the greatest age, way 0 when all are zero
  always_comb begin
    old_way = '0;
    old_age = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (age_i[i] > old_age) begin
        old_age = age_i[i];
        old_way = WAY_W'(i);
      end
    end
  end

  always_comb begin
    if (hit) begin
      way = hit_way;
    end else if (!full) begin
      way = free_way;
    end else if (policy_i == POL_RANDOM) begin
      way = rand_way_i;
    end else begin
      way = old_way;
    end
  end

  always_comb begin
    valid_o = valid_i;
    age_o   = age_i;
    tag_o   = tag_i;
    if (!hit) begin
      if (full && (policy_i == POL_FIFO)) begin
        for (int i = 0; i < WAYS; i++) begin
          age_o[i] = (age_i[i] == AGE_MAX) ? AGE_MAX : age_i[i] + AGE_W'(1);
        end
      end
      valid_o[way] = 1'b1;
      tag_o[way]   = lookup_tag_i;
      age_o[way]   = '0;
    end
  end

  assign res_o.hit      = hit;
  assign res_o.filled   = !hit && !full;
  assign res_o.way      = way;
  assign res_o.rand_adv = !hit && full && (policy_i == POL_RANDOM);

endmodule

// ===== design/four_way_cache_tag_store.sv =====
// top level of the four-way set-associative cache tag store
// depends on fwcts_pkg, fwcts_if, fwcts_tag_ram, fwcts_way_logic and the macro header
`timescale 1ns / 1ps
`include "four_way_cache_tag_store_macros.svh"

// usage
// addr_i takes one byte address per beat; res_o returns one beat per address with
// hit, filled_empty, way_used and the saturating reference and miss totals.
// cfg_i writes replace_policy (index 0) or random_seed (index 1, also reloads the
// lfsr); other indexes are ignored. cfg_i is always ready.
// each address first reads its set row from the tag memory, then compares, picks
// the victim and writes the row back, which also loads the result register. a new
// address is taken only after the write-back of the last one. after reset the block
// sweeps the tag memory once, one set per cycle, clearing valid bits and ages of all
// SET_COUNT (1024 by default) sets, with addr_i not ready. the result register
// decouples the sides: a new address is taken while a result waits, but its
// write-back cycle holds until the result register is free. sets are selected by
// address bits above OFFSET_BITS. SET_COUNT must be a power of two; it is unchecked.
module four_way_cache_tag_store #(
  parameter int unsigned SET_COUNT   = 1024,
  parameter int unsigned OFFSET_BITS = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fwcts_addr_if.sink  addr_i,
  fwcts_res_if.source res_o,
  fwcts_cfg_if.sink   cfg_i
);

  import fwcts_pkg::*;

  localparam int unsigned SET_W = $clog2(SET_COUNT);
  localparam int unsigned TAG_W = ADDR_W - OFFSET_BITS - SET_W;
  localparam int unsigned ROW_W = WAYS * (1 + AGE_W + TAG_W);

  state_e            state_q, state_d;
  logic [SET_W-1:0]  clr_cnt_q;
  logic [SET_W-1:0]  set_q;
  logic [TAG_W-1:0]  tag_q;
  policy_e           policy_q;
  logic [SEED_W-1:0] lfsr_q;
  logic [SEED_W-1:0] lfsr_nx;
  logic [CNT_W-1:0]  ref_cnt_q, ref_d;
  logic [CNT_W-1:0]  miss_cnt_q, miss_d;

  logic             out_valid_q, out_valid_d;
  logic             out_hit_q;
  logic             out_filled_q;
  logic [WAY_W-1:0] out_way_q;
  logic [CNT_W-1:0] out_ref_q;
  logic [CNT_W-1:0] out_miss_q;

  logic             in_acc;
  logic             cfg_acc;
  logic             clearing;
  logic             clr_last;
  logic             done;

  logic             mem_we;
  logic [SET_W-1:0] mem_waddr;
  logic [ROW_W-1:0] mem_wdata;
  logic [ROW_W-1:0] rd_row;
  logic [ROW_W-1:0] new_row;

  logic [WAYS-1:0]             rd_valid;
  logic [WAYS-1:0][AGE_W-1:0]  rd_age;
  logic [WAYS-1:0][TAG_W-1:0]  rd_tag;
  logic [WAYS-1:0]             nw_valid;
  logic [WAYS-1:0][AGE_W-1:0]  nw_age;
  logic [WAYS-1:0][TAG_W-1:0]  nw_tag;
  lookup_t                     look;

  assign addr_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready  = 1'b1;
  assign in_acc       = addr_i.valid && addr_i.ready;
  assign cfg_acc      = cfg_i.valid && cfg_i.ready;
  assign clearing     = (state_q == ST_CLEAR);
  assign clr_last     = (clr_cnt_q == SET_W'(SET_COUNT - 1));
  // write-back waits for room in the result register
  assign done         = (state_q == ST_LOOKUP) && (!out_valid_q || res_o.ready);

  assign mem_we    = clearing || done;
  assign mem_waddr = clearing ? clr_cnt_q : set_q;
  assign mem_wdata = clearing ? '0 : new_row;

  fwcts_tag_ram #(
    .DEPTH (SET_COUNT),
    .WIDTH (ROW_W),
    .AW    (SET_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (in_acc),
    .raddr_i (addr_i.address[OFFSET_BITS +: SET_W]),
    .rdata_o (rd_row)
  );

  assign {rd_valid, rd_age, rd_tag} = rd_row;
  assign new_row = {nw_valid, nw_age, nw_tag};
  assign lfsr_nx = lfsr_next(lfsr_q);

  fwcts_way_logic #(
    .TAG_W (TAG_W)
  ) u_way (
    .valid_i      (rd_valid),
    .age_i        (rd_age),
    .tag_i        (rd_tag),
    .lookup_tag_i (tag_q),
    .policy_i     (policy_q),
    .rand_way_i   (lfsr_nx[WAY_W-1:0]),
    .res_o        (look),
    .valid_o      (nw_valid),
    .age_o        (nw_age),
    .tag_o        (nw_tag)
  );

  assign ref_d  = (ref_cnt_q == '1) ? ref_cnt_q : ref_cnt_q + CNT_W'(1);
  assign miss_d = (look.hit || (miss_cnt_q == '1)) ? miss_cnt_q : miss_cnt_q + CNT_W'(1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) state_d = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        if (done) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (done) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      policy_q    <= POL_FIFO;
      lfsr_q      <= seed_load(SEED_RESET);
      ref_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (clearing) begin
        clr_cnt_q <= clr_cnt_q + SET_W'(1);
      end
      if (done) begin
        ref_cnt_q  <= ref_d;
        miss_cnt_q <= miss_d;
        if (look.rand_adv) lfsr_q <= lfsr_nx;
      end
      if (cfg_acc) begin
        case (cfg_reg_e'(cfg_i.index))
          REG_POLICY: policy_q <= policy_e'(cfg_i.data[0]);
          REG_SEED:   lfsr_q   <= seed_load(cfg_i.data[SEED_W-1:0]);
          default:    ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      set_q <= addr_i.address[OFFSET_BITS +: SET_W];
      tag_q <= addr_i.address[OFFSET_BITS + SET_W +: TAG_W];
    end
    if (done) begin
      out_hit_q    <= look.hit;
      out_filled_q <= look.filled;
      out_way_q    <= look.way;
      out_ref_q    <= ref_d;
      out_miss_q   <= miss_d;
    end
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.hit             = out_hit_q;
  assign res_o.filled_empty    = out_filled_q;
  assign res_o.way_used        = out_way_q;
  assign res_o.reference_total = out_ref_q;
  assign res_o.miss_total      = out_miss_q;

  `FWCTS_ASSERT(a_miss_le_ref, res_o.valid |-> (res_o.miss_total <= res_o.reference_total), "miss total exceeds reference total")
  `FWCTS_ASSERT(a_hit_not_fill, res_o.valid |-> !(res_o.hit && res_o.filled_empty), "hit and fill flagged together")
  `FWCTS_ASSERT(a_out_from_lookup, $rose(out_valid_q) |-> $past(state_q == ST_LOOKUP), "result raised outside a lookup")
  `FWCTS_ASSERT(a_lfsr_nonzero, lfsr_q != '0, "lfsr reached the all-zero lock-up state")
  `FWCTS_ASSERT_NEXT(a_wb_gives_result, mem_we && (state_q == ST_LOOKUP), (state_q == ST_IDLE) && out_valid_q, "write-back without a result beat")

endmodule

// ===== verif/fwcts_lookup_checker.sv =====
// lookup checker for the four-way cache tag store: predicts every result beat
// from the address and config beats it watches, and compares field by field
// depends on fwcts_pkg
`timescale 1ns / 1ps

module fwcts_lookup_checker
  import fwcts_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  addr_valid_i,
  input  logic                  addr_ready_i,
  input  logic [ADDR_W-1:0]     address_i,
  input  logic                  res_valid_i,
  input  logic                  res_ready_i,
  input  logic                  hit_i,
  input  logic                  filled_empty_i,
  input  logic [WAY_W-1:0]      way_used_i,
  input  logic [CNT_W-1:0]      reference_total_i,
  input  logic [CNT_W-1:0]      miss_total_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned           mismatch_count_o,
  output int unsigned           outstanding_o,
  output int unsigned           checked_count_o,
  output int unsigned           hit_count_o
);

  localparam int OFF_W = 6;
  localparam int SET_W = 10;
  localparam int TAG_W = ADDR_W - SET_W - OFF_W;
  localparam int LINES = (1 << SET_W) * WAYS;

  typedef struct packed {
    logic             hit;
    logic             filled_empty;
    logic [WAY_W-1:0] way_used;
    logic [CNT_W-1:0] reference_total;
    logic [CNT_W-1:0] miss_total;
  } lookup_result_t;

  logic             line_valid [LINES];
  logic [TAG_W-1:0] line_tag   [LINES];
  logic [AGE_W-1:0] line_age   [LINES];
  policy_e          policy;
  logic [SEED_W-1:0] way_lfsr;
  logic [CNT_W-1:0] reference_count;
  logic [CNT_W-1:0] miss_count;

  lookup_result_t   expected_results [$];
  int unsigned      mismatches;
  int unsigned      checked;
  int unsigned      hits;

  function automatic logic [CNT_W-1:0] saturating_bump(input logic [CNT_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [CNT_W-1:0] got,
                                 input logic [CNT_W-1:0] want);
    // keep the log short on a badly broken run, but count every one
    if (mismatches < 40)
      $display("[%0t] lookup %0d: %s is %0h, expected %0h", $time, checked, what, got, want);
    mismatches++;
  endtask

  function automatic lookup_result_t predict_lookup(input logic [ADDR_W-1:0] a);
    logic [SET_W-1:0] set_idx;
    logic [TAG_W-1:0] tag;
    logic [AGE_W-1:0] oldest;
    int               base;
    lookup_result_t   r;
    set_idx = a[OFF_W +: SET_W];
    tag     = a[ADDR_W-1 -: TAG_W];
    base    = int'(set_idx) * WAYS;
    r       = '0;
    reference_count = saturating_bump(reference_count);
    for (int w = 0; w < WAYS; w++) begin
      if (!r.hit && line_valid[base + w] && line_tag[base + w] == tag) begin
        r.hit      = 1'b1;
        r.way_used = WAY_W'(w);
      end
    end
    if (!r.hit) begin
      miss_count = saturating_bump(miss_count);
      for (int w = 0; w < WAYS; w++) begin
        if (!r.filled_empty && !line_valid[base + w]) begin
          r.filled_empty = 1'b1;
          r.way_used     = WAY_W'(w);
        end
      end
      if (!r.filled_empty) begin
        if (policy == POL_RANDOM) begin
          // feedback from bits 0, 2, 3 and 5, shifted in at the top
          way_lfsr   = {^(way_lfsr & 16'h002d), way_lfsr[SEED_W-1:1]};
          r.way_used = way_lfsr[WAY_W-1:0];
        end else begin
          // first way holding the greatest age, then age the whole set
          oldest = '0;
          for (int w = 0; w < WAYS; w++) begin
            if (line_age[base + w] > oldest) begin
              oldest     = line_age[base + w];
              r.way_used = WAY_W'(w);
            end
            if (line_age[base + w] != AGE_MAX) line_age[base + w] += 1'b1;
          end
        end
      end
      line_valid[base + r.way_used] = 1'b1;
      line_tag[base + r.way_used]   = tag;
      line_age[base + r.way_used]   = '0;
    end
    r.reference_total = reference_count;
    r.miss_total      = miss_count;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lookup_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < LINES; i++) begin
        line_valid[i] = 1'b0;
        line_tag[i]   = '0;
        line_age[i]   = '0;
      end
      policy          = POL_FIFO;
      way_lfsr        = SEED_RESET;
      reference_count = '0;
      miss_count      = '0;
      expected_results.delete();
      mismatches      = 0;
      checked         = 0;
      hits            = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_POLICY: policy = policy_e'(cfg_data_i[0]);
          REG_SEED: begin
            way_lfsr = (cfg_data_i[SEED_W-1:0] == '0) ? SEED_W'(1) : cfg_data_i[SEED_W-1:0];
          end
          default: ; // spare indexes are ignored
        endcase
      end
      if (res_valid_i && res_ready_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result beat with nothing outstanding, way", CNT_W'(way_used_i), '0);
        end else begin
          want = expected_results.pop_front();
          if (hit_i !== want.hit) report_mismatch("hit", CNT_W'(hit_i), CNT_W'(want.hit));
          if (filled_empty_i !== want.filled_empty)
            report_mismatch("filled_empty", CNT_W'(filled_empty_i), CNT_W'(want.filled_empty));
          if (way_used_i !== want.way_used)
            report_mismatch("way_used", CNT_W'(way_used_i), CNT_W'(want.way_used));
          if (reference_total_i !== want.reference_total)
            report_mismatch("reference_total", reference_total_i, want.reference_total);
          if (miss_total_i !== want.miss_total)
            report_mismatch("miss_total", miss_total_i, want.miss_total);
          if (want.hit) hits++;
          checked++;
        end
      end
      if (addr_valid_i && addr_ready_i) expected_results.push_back(predict_lookup(address_i));
    end
    mismatch_count_o <= mismatches;
    outstanding_o    <= expected_results.size();
    checked_count_o  <= checked;
    hit_count_o      <= hits;
  end

endmodule

// ===== verif/tb_four_way_cache_tag_store.sv =====
// top of the cache tag store testbench: clock, reset, address and config stimulus,
// result back-pressure, watchdog and verdict
// depends on fwcts_pkg, fwcts_if, four_way_cache_tag_store and fwcts_lookup_checker
`timescale 1ns / 1ps

module tb_four_way_cache_tag_store;
  import fwcts_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
  // covers the clearing sweep after reset plus the longest gap and stall
  localparam int unsigned QUIET_LIMIT = 6000;

  logic clk_i;
  logic rst_ni;

  fwcts_addr_if addr_ch ();
  fwcts_res_if  res_ch ();
  fwcts_cfg_if  cfg_ch ();

  int unsigned mismatch_count;
  int unsigned outstanding;
  int unsigned checked_count;
  int unsigned hit_count;

  logic [ADDR_W-1:0] address_plan [$];
  logic [9:0]        hot_sets [6];
  logic [15:0]       hot_tags [8];
  bit                sender_calm;
  int unsigned       addresses_sent;
  int unsigned       register_writes;

  four_way_cache_tag_store dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .addr_i (addr_ch),
    .res_o  (res_ch),
    .cfg_i  (cfg_ch)
  );

  fwcts_lookup_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .addr_valid_i      (addr_ch.valid),
    .addr_ready_i      (addr_ch.ready),
    .address_i         (addr_ch.address),
    .res_valid_i       (res_ch.valid),
    .res_ready_i       (res_ch.ready),
    .hit_i             (res_ch.hit),
    .filled_empty_i    (res_ch.filled_empty),
    .way_used_i        (res_ch.way_used),
    .reference_total_i (res_ch.reference_total),
    .miss_total_i      (res_ch.miss_total),
    .cfg_valid_i       (cfg_ch.valid),
    .cfg_ready_i       (cfg_ch.ready),
    .cfg_index_i       (cfg_ch.index),
    .cfg_data_i        (cfg_ch.data),
    .mismatch_count_o  (mismatch_count),
    .outstanding_o     (outstanding),
    .checked_count_o   (checked_count),
    .hit_count_o       (hit_count)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // mostly short, now and then long
  function automatic int unsigned stall_length();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  task automatic issue_address(input logic [ADDR_W-1:0] a);
    addr_ch.valid   <= 1'b1;
    addr_ch.address <= a;
    do @(posedge clk_i); while (!addr_ch.ready);
    addresses_sent++;
    if (addresses_sent % 64 == 0) sender_calm = ($urandom_range(0, 3) == 0);
    if (!sender_calm && $urandom_range(0, 1) == 1) begin
      addr_ch.valid <= 1'b0;
      repeat (stall_length()) @(posedge clk_i);
    end
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    register_writes++;
    @(posedge clk_i);
  endtask

  task automatic drain_results();
    addr_ch.valid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  task automatic run_plan();
    foreach (address_plan[i]) issue_address(address_plan[i]);
    address_plan.delete();
  endtask

  // most beats reuse a few sets and tags so that hits, fills and evictions all
  // come up; the rest are fully random addresses
  task automatic run_random(input int unsigned count, input bit hold_midway);
    logic [ADDR_W-1:0] a;
    hot_sets[0] = '0;
    hot_sets[1] = '1;
    for (int i = 2; i < 6; i++) hot_sets[i] = 10'($urandom());
    hot_tags[0] = '0;
    hot_tags[1] = '1;
    for (int i = 2; i < 8; i++) hot_tags[i] = 16'($urandom());
    for (int unsigned n = 0; n < count; n++) begin
      if (hold_midway && n == count / 2) drain_results();
      if ($urandom_range(0, 3) == 0)
        a = $urandom();
      else
        a = {hot_tags[$urandom_range(0, 7)], hot_sets[$urandom_range(0, 5)], 6'($urandom())};
      issue_address(a);
    end
  endtask

  initial begin : result_sink
    int unsigned stall_left;
    int unsigned window;
    bit          calm;
    logic        take;
    stall_left = 0;
    window     = 0;
    calm       = 1'b0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (window == 0) begin
        calm   = ($urandom_range(0, 3) == 0);
        window = 200;
      end
      window--;
      if (stall_left > 0) begin
        stall_left--;
        take = 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 30) begin
        stall_left = stall_length() - 1;
        take       = 1'b0;
      end else begin
        take = 1'b1;
      end
      res_ch.ready <= take;
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((addr_ch.valid && addr_ch.ready) || (res_ch.valid && res_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("timeout: no beat for %0d cycles, %0d results outstanding", QUIET_LIMIT,
             outstanding);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin : stimulus
    addresses_sent  = 0;
    register_writes = 0;
    sender_calm     = 1'b0;
    rst_ni          <= 1'b0;
    addr_ch.valid   <= 1'b0;
    addr_ch.address <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= REG_POLICY;
    cfg_ch.data     <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: fifo. lowest and highest addresses, then set 0 filled and
    // evicted until the ages pin at the top
    address_plan.push_back(32'h0000_0000);
    address_plan.push_back(32'h0000_003f);
    address_plan.push_back(32'hffff_ffff);
    address_plan.push_back(32'hffff_ffc0);
    for (int t = 1; t <= 8; t++) address_plan.push_back({16'(t), 10'd0, 6'd0});
    address_plan.push_back({16'd8, 10'd0, 6'd21});
    address_plan.push_back({16'd0, 10'd0, 6'd0});
    address_plan.push_back(32'h0000_0040);
    run_plan();
    run_random(135, 1'b0);
    drain_results();

    // random eviction from the reset seed, junk above the policy bit
    write_register(REG_POLICY, {15'($urandom()), POL_RANDOM});
    for (int t = 10; t < 18; t++) address_plan.push_back({16'(t), 10'd77, 6'd0});
    run_plan();
    run_random(135, 1'b0);
    drain_results();

    write_register(REG_SEED, 16'hffff);
    run_random(135, 1'b1);
    drain_results();

    // zero seed has to come up as one
    write_register(REG_SEED, 16'h0000);
    run_random(135, 1'b0);
    drain_results();

    write_register(REG_SPARE_2, 16'($urandom()));
    write_register(REG_SPARE_3, 16'($urandom()));
    write_register(REG_SEED, 16'h0001);
    write_register(REG_POLICY, {15'($urandom()), POL_FIFO});
    run_random(135, 1'b0);
    drain_results();

    write_register(REG_POLICY, {15'($urandom()), POL_RANDOM});
    write_register(REG_SEED, 16'($urandom_range(1, 65535)));
    run_random(135, 1'b0);
    drain_results();
    repeat (6) @(posedge clk_i);

    $display("run: %0d addresses, %0d register writes, fifo and random eviction,",
             addresses_sent, register_writes);
    $display("     seeds at reset, zero, one, all ones; %0d results checked, %0d hits",
             checked_count, hit_count);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/fwcts_pkg.sv
design/fwcts_if.sv
design/fwcts_tag_ram.sv
design/fwcts_way_logic.sv
design/four_way_cache_tag_store.sv
verif/fwcts_lookup_checker.sv
verif/tb_four_way_cache_tag_store.sv
